@@ src/terrain_heightmap_classifier_unit_defines.svh @@
// ------------------------------------------------------------------------
// terrain heightmap classifier assertion macros
// shared property forms for the block's concurrent checks
// ------------------------------------------------------------------------
`ifndef TERRAIN_HEIGHTMAP_CLASSIFIER_UNIT_DEFINES_SVH
`define TERRAIN_HEIGHTMAP_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define THC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define THC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/thc_pkg.sv @@
// ------------------------------------------------------------------------
// thc_pkg
// types and constants shared by the terrain heightmap classifier
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thc_pkg;

    // actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // cell classes
    localparam logic [2:0] CLS_UNKNOWN  = 3'd0;
    localparam logic [2:0] CLS_TRAVERSE = 3'd1;
    localparam logic [2:0] CLS_OBST_UP  = 3'd2;
    localparam logic [2:0] CLS_CLIFF    = 3'd3;
    localparam logic [2:0] CLS_STEEP    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_NORMAL_X  = 3'd0;
    localparam logic [2:0] CFG_NORMAL_Y  = 3'd1;
    localparam logic [2:0] CFG_NORMAL_Z  = 3'd2;
    localparam logic [2:0] CFG_OFFSET    = 3'd3;
    localparam logic [2:0] CFG_STEP_UP   = 3'd4;
    localparam logic [2:0] CFG_DROP_DOWN = 3'd5;
    localparam logic [2:0] CFG_COS_TILT  = 3'd6;
    localparam logic [2:0] CFG_PLANE_OK  = 3'd7;

    // reset values
    localparam logic [15:0] RST_NORMAL_Z = 16'd32767;
    localparam logic [14:0] RST_STEP_UP  = 15'd100;
    localparam logic [14:0] RST_DROP     = 15'd150;
    localparam logic [14:0] RST_COS      = 15'd30792;

    // datapath widths, sized for the full range of the grid parameters
    localparam int WX_W  = 22;  // doubled cell centre coordinate
    localparam int PW_W  = 38;  // normal times centre coordinate
    localparam int SUM_W = 40;  // height numerator
    localparam int NUM_W = 41;  // rounded dividend
    localparam int DEN_W = 18;  // rounded divisor
    localparam int Q_W   = 17;  // quotient bits before saturation
    localparam int CNT_W = 5;   // divider step counter

    typedef struct packed {
        logic        seen;
        logic [14:0] max_up;
        logic [14:0] max_down;
    } cell_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD_MUL,
        ST_ADD_BIN,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_RD_IDX,
        ST_RD_MUL,
        ST_RD_CHK,
        ST_RD_DIV
    } state_t;

endpackage

`default_nettype wire

@@ src/thc_grid_mem.sv @@
// ------------------------------------------------------------------------
// thc_grid_mem
// per-cell store: seen mark and height extremes, one write and one read port
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thc_grid_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire thc_pkg::cell_t      wdata,
    input  wire logic                re,
    input  wire logic [ADDR_W-1:0]   raddr,
    output thc_pkg::cell_t           rdata
);
    import thc_pkg::*;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/thc_div.sv @@
// ------------------------------------------------------------------------
// thc_div
// restoring divider, one quotient bit a cycle, with overflow flag
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [thc_pkg::NUM_W-1:0]   num,
    input  wire logic [thc_pkg::DEN_W-1:0]   den,
    output logic                             done,
    output logic [thc_pkg::Q_W-1:0]          quot,
    output logic                             ovf
);
    import thc_pkg::*;

    localparam int SH_W = DEN_W + Q_W - 1;

    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [NUM_W-1:0]     rem_reg;
    logic [SH_W-1:0]      dsh_reg;
    logic [Q_W-1:0]       q_reg;
    logic                 ovf_reg;
    logic                 ge;

    assign ge = rem_reg >= NUM_W'(dsh_reg);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(Q_W - 1);
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, {(Q_W - 1){1'b0}}};
            q_reg   <= '0;
            ovf_reg <= num >= NUM_W'({den, {Q_W{1'b0}}});
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
            end
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

@@ src/terrain_heightmap_classifier_unit.sv @@
// ------------------------------------------------------------------------
// terrain_heightmap_classifier_unit
// 2.5d elevation grid: bins points into cells and classifies cells
// ------------------------------------------------------------------------
// Pulse start with busy low to issue a transaction. Every transaction gives
// exactly one result, shown for a single cycle with done high; the receiver
// must take it then. Cell state lives in one memory with a single write port
// and a registered read port, and each transaction finishes before the next
// is taken. An add point passes through the multiply and binning states, the
// memory read, then the write-back; a dropped point ends after the memory
// read state. A read of an unknown cell or with a zero normal_z ends after its
// index, multiply and check states; any other read also waits for the 17-step
// divider for the plane height. A clear sweeps the memory one entry a cycle.
// After reset the same sweep runs (busy high, no result); configuration
// writes are taken at any time, but should only be made while busy is low.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "terrain_heightmap_classifier_unit_defines.svh"

module terrain_heightmap_classifier_unit #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64,
    parameter int CELL_MM   = 50,
    parameter int MIN_X_MM  = 0,
    parameter int Y_HALF_MM = 1600
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic signed [15:0] point_z,
    input  wire logic [5:0]         cell_col,
    input  wire logic [5:0]         cell_row,
    output logic                    done,
    output logic                    map_valid,
    output logic                    point_accepted,
    output logic [2:0]              cell_class,
    output logic signed [15:0]      plane_height_mm,
    output logic                    height_error,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import thc_pkg::*;

    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int IDX_W  = $clog2(NCELLS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int RSH    = 24;
    localparam int unsigned RECIP  = (1 << RSH) / CELL_MM;
    localparam int unsigned X_SPAN = GRID_COLS * CELL_MM;
    localparam int unsigned Y_SPAN = GRID_ROWS * CELL_MM;
    localparam logic [24:0] RECIP_V = 25'(RECIP);
    localparam logic [31:0] CELL_V  = 32'(CELL_MM);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCELLS - 1);

    // configuration
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic signed [15:0] d_reg;
    logic [14:0]        up_lim_reg;
    logic [14:0]        dn_lim_reg;
    logic [14:0]        cos_reg;
    logic               plane_ok_reg;

    // control
    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [IDX_W-1:0]   clr_cnt_next;
    logic               clr_report_reg;
    logic               clr_report_next;
    logic               done_reg;
    logic               done_next;

    // result fields
    logic               res_mv_reg;
    logic               res_acc_reg;
    logic               res_acc_next;
    logic [2:0]         res_cls_reg;
    logic [2:0]         res_cls_next;
    logic signed [15:0] res_h_reg;
    logic signed [15:0] res_h_next;
    logic               res_err_reg;
    logic               res_err_next;

    // transaction payload
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    logic signed [15:0] pz_reg;
    logic [5:0]         ccol_reg;
    logic [5:0]         crow_reg;

    // add point datapath
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic [40:0]        mx;
    logic [40:0]        my;
    logic signed [31:0] ppx;
    logic signed [31:0] ppy;
    logic signed [31:0] ppz;
    logic signed [16:0] ax_reg;
    logic signed [16:0] ay_reg;
    logic [COL_W-1:0]   qx0_reg;
    logic [ROW_W-1:0]   qy0_reg;
    logic               inx_reg;
    logic               iny_reg;
    logic signed [31:0] ppx_reg;
    logic signed [31:0] ppy_reg;
    logic signed [31:0] ppz_reg;
    logic signed [33:0] sum34;
    logic signed [18:0] s_dist;
    logic signed [19:0] s_neg;
    logic [14:0]        up_val;
    logic [14:0]        dn_val;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [14:0]        up_reg;
    logic [14:0]        dn_reg;
    logic               inside_reg;
    logic [IDX_W-1:0]   add_idx;
    logic [IDX_W-1:0]   widx_reg;
    cell_t              upd_cell;

    // read cell datapath
    logic               rd_ok;
    logic [IDX_W-1:0]   rd_idx;
    logic               rdok_reg;
    logic signed [WX_W-1:0] wx2_reg;
    logic signed [WX_W-1:0] wy2_reg;
    logic signed [PW_W-1:0] pwx;
    logic signed [PW_W-1:0] pwy;
    logic signed [PW_W-1:0] pwx_reg;
    logic signed [PW_W-1:0] pwy_reg;
    logic               seen_reg;
    logic [2:0]         cls_reg;
    logic [2:0]         cls_now;
    logic signed [SUM_W-1:0] dterm;
    logic signed [SUM_W-1:0] num_s;
    logic [SUM_W-1:0]   an;
    logic signed [DEN_W-1:0] den2;
    logic [DEN_W-1:0]   ad;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               neg_now;
    logic               neg_reg;
    logic               div_start;
    logic               div_done;
    logic [Q_W-1:0]     div_q;
    logic               div_ovf;
    logic signed [15:0] h_sat;
    logic               h_err;

    // memory ports
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    cell_t              mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    cell_t              mem_rdata;

    logic               accept;

    assign accept = start && (state_reg == ST_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg       <= '0;
            ny_reg       <= '0;
            nz_reg       <= RST_NORMAL_Z;
            d_reg        <= '0;
            up_lim_reg   <= RST_STEP_UP;
            dn_lim_reg   <= RST_DROP;
            cos_reg      <= RST_COS;
            plane_ok_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMAL_X:  nx_reg       <= cfg_data;
                CFG_NORMAL_Y:  ny_reg       <= cfg_data;
                CFG_NORMAL_Z:  nz_reg       <= cfg_data;
                CFG_OFFSET:    d_reg        <= cfg_data;
                CFG_STEP_UP:   up_lim_reg   <= cfg_data[14:0];
                CFG_DROP_DOWN: dn_lim_reg   <= cfg_data[14:0];
                CFG_COS_TILT:  cos_reg      <= cfg_data[14:0];
                CFG_PLANE_OK:  plane_ok_reg <= cfg_data[0];
                default:       plane_ok_reg <= plane_ok_reg;
            endcase
        end
    end

    // add point: binning and plane distance
    assign ax  = {px_reg[15], px_reg} - 17'(MIN_X_MM);
    assign ay  = {py_reg[15], py_reg} + 17'(Y_HALF_MM);
    assign mx  = ax[15:0] * RECIP_V;
    assign my  = ay[15:0] * RECIP_V;
    assign ppx = nx_reg * px_reg;
    assign ppy = ny_reg * py_reg;
    assign ppz = nz_reg * pz_reg;

    assign sum34  = ppx_reg + ppy_reg + ppz_reg + $signed({{3{d_reg[15]}}, d_reg, 15'd0});
    assign s_dist = sum34[33:15];
    assign s_neg  = -{s_dist[18], s_dist};
    assign up_val = s_dist[18] ? 15'd0 : ((s_dist[17:15] != 3'd0) ? 15'h7fff : s_dist[14:0]);
    assign dn_val = s_neg[19] ? 15'd0 : ((s_neg[18:15] != 4'd0) ? 15'h7fff : s_neg[14:0]);

    // reciprocal estimate is at most one low
    assign rx = {15'd0, ax_reg[16:0]} - 32'(qx0_reg) * CELL_V;
    assign ry = {15'd0, ay_reg[16:0]} - 32'(qy0_reg) * CELL_V;

    assign add_idx = IDX_W'(int'(row_reg) * GRID_COLS + int'(col_reg));

    always_comb
    begin
        upd_cell.seen = 1'b1;
        if (!mem_rdata.seen)
        begin
            upd_cell.max_up   = up_reg;
            upd_cell.max_down = dn_reg;
        end
        else
        begin
            upd_cell.max_up   = (up_reg > mem_rdata.max_up) ? up_reg : mem_rdata.max_up;
            upd_cell.max_down = (dn_reg > mem_rdata.max_down) ? dn_reg : mem_rdata.max_down;
        end
    end

    // read cell: index, classify, height
    assign rd_ok  = plane_ok_reg && (int'(ccol_reg) < GRID_COLS) && (int'(crow_reg) < GRID_ROWS);
    assign rd_idx = IDX_W'(int'(crow_reg) * GRID_COLS + int'(ccol_reg));
    assign pwx    = nx_reg * wx2_reg;
    assign pwy    = ny_reg * wy2_reg;

    always_comb
    begin
        if (mem_rdata.max_up > up_lim_reg)
        begin
            cls_now = CLS_OBST_UP;
        end
        else if (mem_rdata.max_down > dn_lim_reg)
        begin
            cls_now = CLS_CLIFF;
        end
        else if (nz_reg[15] || (nz_reg[14:0] < cos_reg))
        begin
            cls_now = CLS_STEEP;
        end
        else
        begin
            cls_now = CLS_TRAVERSE;
        end
    end

    assign dterm   = {{8{d_reg[15]}}, d_reg, 16'd0};
    assign num_s   = -(pwx_reg + pwy_reg + dterm);
    assign an      = num_s[SUM_W-1] ? SUM_W'(-num_s) : SUM_W'(num_s);
    assign den2    = {{(DEN_W - 17){nz_reg[15]}}, nz_reg, 1'b0};
    assign ad      = den2[DEN_W-1] ? DEN_W'(-den2) : DEN_W'(den2);
    assign neg_now = num_s[SUM_W-1] != nz_reg[15];
    assign div_num = {an, 1'b0} + NUM_W'(ad);
    assign div_den = {ad[DEN_W-2:0], 1'b0};

    // saturate the rounded magnitude with its sign
    always_comb
    begin
        h_err = 1'b0;
        h_sat = '0;
        if (!neg_reg)
        begin
            if (div_ovf || (div_q > Q_W'(32767)))
            begin
                h_sat = 16'sh7fff;
                h_err = 1'b1;
            end
            else
            begin
                h_sat = div_q[15:0];
            end
        end
        else
        begin
            if (div_ovf || (div_q > Q_W'(32768)))
            begin
                h_sat = 16'sh8000;
                h_err = 1'b1;
            end
            else
            begin
                h_sat = 16'(-div_q);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_ADD:   state_next = ST_ADD_MUL;
                        ACT_READ:  state_next = ST_RD_IDX;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_MUL: state_next = ST_ADD_BIN;
            ST_ADD_BIN: state_next = ST_ADD_RD;
            ST_ADD_RD:  state_next = inside_reg ? ST_ADD_WR : ST_IDLE;
            ST_ADD_WR:  state_next = ST_IDLE;
            ST_RD_IDX:  state_next = ST_RD_MUL;
            ST_RD_MUL:  state_next = ST_RD_CHK;
            ST_RD_CHK:
            begin
                if (seen_reg && (nz_reg != '0))
                begin
                    state_next = ST_RD_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        done_next       = 1'b0;
        res_acc_next    = 1'b0;
        res_cls_next    = CLS_UNKNOWN;
        res_h_next      = '0;
        res_err_next    = 1'b0;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        mem_we          = 1'b0;
        mem_waddr       = widx_reg;
        mem_wdata       = upd_cell;
        mem_re          = 1'b0;
        mem_raddr       = add_idx;
        div_start       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_CLEAR)
                    begin
                        clr_report_next = 1'b1;
                    end
                    else if (action == ACT_NOP)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    clr_cnt_next    = '0;
                    done_next       = clr_report_reg;
                    clr_report_next = 1'b0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_ADD_RD:
            begin
                mem_re = inside_reg;
                if (!inside_reg)
                begin
                    done_next = 1'b1;
                end
            end
            ST_ADD_WR:
            begin
                mem_we       = 1'b1;
                done_next    = 1'b1;
                res_acc_next = 1'b1;
            end
            ST_RD_IDX:
            begin
                mem_re    = rd_ok;
                mem_raddr = rd_idx;
            end
            ST_RD_CHK:
            begin
                if (!seen_reg)
                begin
                    done_next = 1'b1;
                end
                else if (nz_reg == '0)
                begin
                    done_next    = 1'b1;
                    res_cls_next = cls_reg;
                    res_err_next = 1'b1;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_RD_DIV:
            begin
                if (div_done)
                begin
                    done_next    = 1'b1;
                    res_cls_next = cls_reg;
                    res_h_next   = h_sat;
                    res_err_next = h_err;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            pz_reg   <= point_z;
            ccol_reg <= cell_col;
            crow_reg <= cell_row;
        end
        if (state_reg == ST_ADD_MUL)
        begin
            ax_reg  <= ax;
            ay_reg  <= ay;
            qx0_reg <= mx[RSH +: COL_W];
            qy0_reg <= my[RSH +: ROW_W];
            inx_reg <= !ax[16] && ({15'd0, ax} < X_SPAN);
            iny_reg <= !ay[16] && ({15'd0, ay} < Y_SPAN);
            ppx_reg <= ppx;
            ppy_reg <= ppy;
            ppz_reg <= ppz;
        end
        if (state_reg == ST_ADD_BIN)
        begin
            col_reg    <= (rx >= CELL_V) ? COL_W'(qx0_reg + 1'b1) : qx0_reg;
            row_reg    <= (ry >= CELL_V) ? ROW_W'(qy0_reg + 1'b1) : qy0_reg;
            up_reg     <= up_val;
            dn_reg     <= dn_val;
            inside_reg <= plane_ok_reg && inx_reg && iny_reg;
        end
        if (state_reg == ST_ADD_RD)
        begin
            widx_reg <= add_idx;
        end
        if (state_reg == ST_RD_IDX)
        begin
            rdok_reg <= rd_ok;
            wx2_reg  <= WX_W'(2 * MIN_X_MM + (2 * int'(ccol_reg) + 1) * CELL_MM);
            wy2_reg  <= WX_W'(-2 * Y_HALF_MM + (2 * int'(crow_reg) + 1) * CELL_MM);
        end
        if (state_reg == ST_RD_MUL)
        begin
            pwx_reg  <= pwx;
            pwy_reg  <= pwy;
            seen_reg <= rdok_reg && mem_rdata.seen;
            cls_reg  <= cls_now;
        end
        if (state_reg == ST_RD_CHK)
        begin
            neg_reg <= neg_now;
        end
        if (done_next)
        begin
            res_mv_reg  <= plane_ok_reg;
            res_acc_reg <= res_acc_next;
            res_cls_reg <= res_cls_next;
            res_h_reg   <= res_h_next;
            res_err_reg <= res_err_next;
        end
    end

    thc_grid_mem #(
        .DEPTH  (NCELLS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    thc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q),
        .ovf   (div_ovf)
    );

    assign busy            = state_reg != ST_IDLE;
    assign done            = done_reg;
    assign map_valid       = res_mv_reg;
    assign point_accepted  = res_acc_reg;
    assign cell_class      = res_cls_reg;
    assign plane_height_mm = res_h_reg;
    assign height_error    = res_err_reg;

    // a real transaction leaves idle at once
    `THC_ASSERT_NXT(a_start_busy, start && !busy && (action != ACT_NOP), busy, "start not taken")
    // only the clearing sweep writes the memory without a plane
    `THC_ASSERT_IMP(a_write_plane, mem_we && (state_reg != ST_CLEAR), plane_ok_reg, "write without plane")
    // a height error only comes with a classified cell
    `THC_ASSERT_IMP(a_err_class, done && height_error, cell_class != CLS_UNKNOWN, "error on unknown cell")
    // an accepted point never carries a class
    `THC_ASSERT_IMP(a_acc_clean, done && point_accepted, (cell_class == CLS_UNKNOWN) && map_valid, "point result dirty")

endmodule

`default_nettype wire
